// ----- hdl/ifla_pkg.sv -----
// Shared types and constants for the index free-list allocator.
// Used by the channel interfaces and the top level; depends on nothing else.
package ifla_pkg;

    // Default pool size and fixed field widths.
    localparam int SLOTS_DEF = 16;
    localparam int INDEX_W   = 8;
    localparam int STATUS_W  = 2;

    // Request opcodes.
    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK           = 2'd0,
        ST_NONE_FREE    = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

endpackage

// ----- hdl/ifla_cmd_if.sv -----
// Request channel of the allocator: valid/ready handshake with opcode and index.
// Depends on ifla_pkg.
interface ifla_cmd_if;
    import ifla_pkg::*;

    logic               valid;
    logic               ready;
    op_t                op;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output op, output index, input ready);
    modport sink   (input valid, input op, input index, output ready);

endinterface

// ----- hdl/ifla_res_if.sv -----
// Result channel of the allocator: valid/ready handshake with status and slot.
// Depends on ifla_pkg; the slot width follows the pool size.
interface ifla_res_if #(
    parameter int SLOT_W = $clog2(ifla_pkg::SLOTS_DEF)
);
    import ifla_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);

endinterface

// ----- hdl/index_free_list_allocator.sv -----
// An accepted request is captured with its synchronous reads of the free stack and in-use
// memories; the execute step then does the read-modify-write and loads the output register,
// waiting while it holds an unread result. No new request is taken before that step ends.
// A finished result waits in an output register while the next request is taken.
// Reset: every slot free, highest index handed out first; per-entry valid flops
// stand in for the memory reset values, so no clearing pass is needed.
module index_free_list_allocator #(
    parameter int SLOTS = ifla_pkg::SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ifla_cmd_if.sink   cmd,
    ifla_res_if.source result
);
    import ifla_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [INDEX_W:0]   SLOTS_IX  = (INDEX_W + 1)'(SLOTS);

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    // Control state.
    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               res_vld_reg;
    status_t            res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;

    // Valid flags: an entry never written reads as its reset value.
    logic [SLOTS-1:0]   stack_vld_reg;
    logic [SLOTS-1:0]   iu_vld_reg;

    // Storage.
    logic [SLOT_W-1:0]  stack_mem [SLOTS];
    logic               iu_mem [SLOTS];

    // Captured request and read data.
    op_t                op_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic               in_range_reg;
    logic [SLOT_W-1:0]  stack_rd_reg;
    logic [SLOT_W-1:0]  stack_addr_reg;
    logic               stack_hit_reg;
    logic               iu_rd_reg;
    logic               iu_hit_reg;

    // Datapath signals.
    logic               cmd_fire;
    logic               in_range;
    logic [CNT_W-1:0]   cnt_dec;
    logic [SLOT_W-1:0]  top_addr;
    logic [SLOT_W-1:0]  cmd_idx;
    logic               done;
    logic [SLOT_W-1:0]  slot_pop;
    logic               iu_flag;
    status_t            status_next;
    logic [SLOT_W-1:0]  slot_next;
    logic               stack_we;
    logic [SLOT_W-1:0]  stack_wa;
    logic [SLOT_W-1:0]  stack_wd;
    logic               iu_we;
    logic [SLOT_W-1:0]  iu_wa;
    logic               iu_wd;

    // Request acceptance and read addresses.
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign in_range  = ((INDEX_W + 1)'(cmd.index) < SLOTS_IX);
    assign cmd_idx   = cmd.index[SLOT_W-1:0];
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign top_addr  = cnt_dec[SLOT_W-1:0];

    // Result channel.
    assign result.valid  = res_vld_reg;
    assign result.status = res_status_reg;
    assign result.slot   = res_slot_reg;

    // The execute step completes once the output register can take the result.
    assign done     = (state_reg == S_EXEC) && (!res_vld_reg || result.ready);
    assign slot_pop = stack_hit_reg ? stack_rd_reg : stack_addr_reg;
    assign iu_flag  = iu_hit_reg && iu_rd_reg;

    // Decide the outcome and the write-back from the data read when the request was accepted.
    always_comb
    begin
        status_next = ST_OK;
        slot_next   = '0;
        cnt_next    = cnt_reg;
        stack_we    = 1'b0;
        stack_wa    = cnt_reg[SLOT_W-1:0];
        stack_wd    = idx_reg;
        iu_we       = 1'b0;
        iu_wa       = idx_reg;
        iu_wd       = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (cnt_reg == '0)
                begin
                    status_next = ST_NONE_FREE;
                end
                else
                begin
                    slot_next = slot_pop;
                    cnt_next  = cnt_dec;
                    iu_we     = 1'b1;
                    iu_wa     = slot_pop;
                    iu_wd     = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (!in_range_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (!iu_flag || cnt_reg >= SLOTS_CNT)
                begin
                    status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    stack_we = 1'b1;
                    iu_we    = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // State machine, counter, valid flags and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= SLOTS_CNT;
            res_vld_reg   <= 1'b0;
            stack_vld_reg <= '0;
            iu_vld_reg    <= '0;
        end
        else
        begin
            if (done)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        state_reg   <= S_IDLE;
                        cnt_reg     <= cnt_next;
                        if (stack_we)
                        begin
                            stack_vld_reg[stack_wa] <= 1'b1;
                        end
                        if (iu_we)
                        begin
                            iu_vld_reg[iu_wa] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_status_reg <= status_next;
            res_slot_reg   <= slot_next;
        end
    end

    // Request capture and the valid-flag lookups that go with the memory reads.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg         <= cmd.op;
            idx_reg        <= cmd_idx;
            in_range_reg   <= in_range;
            stack_addr_reg <= top_addr;
            if (cnt_reg != '0)
            begin
                stack_hit_reg <= stack_vld_reg[top_addr];
            end
            if (in_range)
            begin
                iu_hit_reg <= iu_vld_reg[cmd_idx];
            end
        end
    end

    // Free stack memory: one synchronous read, one write.
    always_ff @(posedge clk)
    begin
        if (cmd_fire && cnt_reg != '0)
        begin
            stack_rd_reg <= stack_mem[top_addr];
        end
        if (done && stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
    end

    // In-use flag memory: one synchronous read, one write.
    always_ff @(posedge clk)
    begin
        if (cmd_fire && in_range)
        begin
            iu_rd_reg <= iu_mem[cmd_idx];
        end
        if (done && iu_we)
        begin
            iu_mem[iu_wa] <= iu_wd;
        end
    end

    // The free count never exceeds the pool size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SLOTS_CNT)
        else $error("free count above pool size");

    // Only one request is in flight at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("request taken while another is in flight");

    // A successful allocate pops exactly one entry.
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && op_reg == OP_ALLOC && status_next == ST_OK
        |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("allocate did not pop the free stack");

    // A failed request never reports a slot.
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != ST_OK |-> result.slot == '0)
        else $error("slot reported on a failed request");

endmodule
